// File: rtl/rcdc_pkg.sv
package rcdc_pkg;

  // Stream payload widths
  localparam int InDataW  = 72;
  localparam int OutDataW = 24;
  localparam int ThrustW  = 11;
  localparam int PulseW   = 12;

  // Pulse mapping: (p - 1050) * 200 / 840 - 100 == (p - 1050) * 5 / 21 - 100
  localparam int MapInLo   = 1050;
  localparam int MapOutLo  = -100;
  // floor(m / 21) == (m * 798916) >> 24 for every m below 2^14
  localparam int RecipK    = 798916;
  localparam int RecipW    = 20;
  localparam int RecipSh   = 24;

  // Register reset values
  localparam logic [6:0]  DeadzoneRst  = 7'd10;
  localparam logic [6:0]  JoySpeedRst  = 7'd20;
  localparam logic [15:0] HoldMsRst    = 16'd500;
  localparam logic [11:0] SwThreshRst  = 12'd1800;

  typedef enum logic [1:0] {
    REG_DEADZONE  = 2'd0,
    REG_JOY_SPEED = 2'd1,
    REG_HOLD_MS   = 2'd2,
    REG_SW_THRESH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]       now_ms;
    logic              joy_left;
    logic              joy_right;
    logic              joy_back;
    logic              joy_forward;
    logic [PulseW-1:0] switch_pulse;
    logic [PulseW-1:0] turn_pulse;
    logic [PulseW-1:0] forward_pulse;
  } sample_t;

  typedef struct packed {
    logic        joy_forward;
    logic        joy_back;
    logic        joy_right;
    logic        joy_left;
    logic [31:0] now_ms;
  } joy_sample_t;

  typedef struct packed {
    logic [6:0]  joy_speed;
    logic [15:0] hold_ms;
  } joy_cfg_t;

  // Direction (-1, 0, 1) times speed; no multiplier needed
  function automatic logic signed [ThrustW-1:0] scale_dir(
    input logic signed [1:0] dir,
    input logic [6:0]        speed
  );
    logic signed [ThrustW-1:0] s;
    s = $signed({{(ThrustW-7){1'b0}}, speed});
    priority if (dir == 2'sd1) begin
      return s;
    end else if (dir == -2'sd1) begin
      return -s;
    end else begin
      return '0;
    end
  endfunction

endpackage

// File: rtl/rcdc_radio_map.sv
module rcdc_radio_map
  import rcdc_pkg::*;
(
  input  logic [PulseW-1:0]         pulse,
  input  logic                      negate,
  input  logic [6:0]                deadzone,
  output logic signed [ThrustW-1:0] thrust
);

  logic signed [12:0]             x;
  logic signed [14:0]             x5;
  logic [13:0]                    mag5;
  logic [RecipW+13:0]             prod;
  logic [9:0]                     quo;
  logic signed [ThrustW-1:0]      q_s;
  logic signed [ThrustW-1:0]      mapped;
  logic signed [ThrustW-1:0]      v;
  logic [ThrustW-1:0]             v_mag;
  logic signed [ThrustW-1:0]      dz_s;

  always_comb begin
    x    = $signed({1'b0, pulse}) - 13'(MapInLo);
    x5   = 15'(x) * 15'sd5;
    mag5 = x5[14] ? 14'(-x5) : 14'(x5);
    prod = mag5 * RecipW'(RecipK);
    quo  = prod[RecipSh+9:RecipSh];
    // Truncation toward zero: divide the magnitude, restore the sign
    q_s    = x5[14] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    mapped = q_s + ThrustW'(MapOutLo);
    v      = negate ? -mapped : mapped;
    v_mag  = v[ThrustW-1] ? ThrustW'(-v) : ThrustW'(v);
    dz_s   = $signed({{(ThrustW-7){1'b0}}, deadzone});
    if (v_mag < {{(ThrustW-7){1'b0}}, deadzone}) begin
      thrust = '0;
    end else if (v > 0) begin
      thrust = v - dz_s;
    end else begin
      thrust = v + dz_s;
    end
  end

endmodule

// File: rtl/rcdc_joy_hold.sv
module rcdc_joy_hold
  import rcdc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      upd,
  input  joy_sample_t               smp,
  input  joy_cfg_t                  cfg,
  output logic signed [ThrustW-1:0] thrust_fwd,
  output logic signed [ThrustW-1:0] thrust_turn,
  output logic signed [1:0]         held_fwd_o,
  output logic signed [1:0]         held_turn_o
);

  logic              hold_active_r, hold_active_nxt;
  logic [31:0]       hold_start_r, hold_start_nxt;
  logic signed [1:0] held_fwd_r, held_fwd_nxt;
  logic signed [1:0] held_turn_r, held_turn_nxt;
  logic signed [1:0] fb, lr, fb_out, lr_out;
  logic [31:0]       elapsed;
  logic              pushed;
  logic              in_window;

  always_comb begin
    fb = smp.joy_forward ? 2'sd1 : (smp.joy_back ? -2'sd1 : 2'sd0);
    lr = smp.joy_right   ? 2'sd1 : (smp.joy_left ? -2'sd1 : 2'sd0);
    pushed    = (fb != 2'sd0) || (lr != 2'sd0);
    elapsed   = smp.now_ms - hold_start_r;
    in_window = elapsed < {16'd0, cfg.hold_ms};

    hold_active_nxt = hold_active_r;
    hold_start_nxt  = hold_start_r;
    held_fwd_nxt    = held_fwd_r;
    held_turn_nxt   = held_turn_r;
    fb_out          = fb;
    lr_out          = lr;

    priority if (!hold_active_r && pushed) begin
      // first push after a stop: latch it
      hold_start_nxt  = smp.now_ms;
      held_fwd_nxt    = fb;
      held_turn_nxt   = lr;
      hold_active_nxt = 1'b1;
    end else if (in_window) begin
      fb_out = held_fwd_r;
      lr_out = held_turn_r;
    end else if (!pushed) begin
      hold_active_nxt = 1'b0;
    end else begin
      hold_active_nxt = hold_active_r;
    end

    thrust_fwd  = scale_dir(fb_out, cfg.joy_speed);
    thrust_turn = scale_dir(lr_out, cfg.joy_speed);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_active_r <= 1'b0;
      hold_start_r  <= '0;
      held_fwd_r    <= '0;
      held_turn_r   <= '0;
    end else if (upd) begin
      hold_active_r <= hold_active_nxt;
      hold_start_r  <= hold_start_nxt;
      held_fwd_r    <= held_fwd_nxt;
      held_turn_r   <= held_turn_nxt;
    end
  end

  assign held_fwd_o  = held_fwd_r;
  assign held_turn_o = held_turn_r;

endmodule

// File: rtl/rc_drive_command_conditioner.sv
// Path: an accepted item goes through the input register, one combinational pass and the
//   result register, which drives out_tvalid.
// Throughput: one item per cycle while out_tready is high; the single pass through
//   map/deadzone or the joystick hold logic is all that stands between the two registers.
// Reset (rst_n, synchronous, active low): both stages empty, joystick latch cleared,
//   configuration registers back to deadzone 10, speed 20, hold 500 ms, threshold 1800.
module rc_drive_command_conditioner
  import rcdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata, low bit up: forward_pulse[11:0], turn_pulse[23:12], switch_pulse[35:24],
  //   joy_forward[36], joy_back[37], joy_right[38], joy_left[39], now_ms[71:40]
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  // in_tuser: frame_valid[0]
  input  logic                in_tuser,
  // out_tdata, low bit up: thrust_forward[10:0], thrust_turn[21:11], zero pad[23:22]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers; writes are always taken
  // ---------------------------------------------------------------------------
  logic [6:0]  deadzone_r;
  logic [6:0]  joy_speed_r;
  logic [15:0] hold_ms_r;
  logic [11:0] sw_thresh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r  <= DeadzoneRst;
      joy_speed_r <= JoySpeedRst;
      hold_ms_r   <= HoldMsRst;
      sw_thresh_r <= SwThreshRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEADZONE:  deadzone_r  <= cfg_data[6:0];
        REG_JOY_SPEED: joy_speed_r <= cfg_data[6:0];
        REG_HOLD_MS:   hold_ms_r   <= cfg_data;
        REG_SW_THRESH: sw_thresh_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Two-stage pipe: input register -> result register. The result register
  // frees the input side, so a new item is taken while a result waits.
  // ---------------------------------------------------------------------------
  logic                s0_valid_r, s0_valid_nxt;
  logic                s0_frame_r;
  sample_t             s0_smp_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  logic                out_load;
  logic                s0_fire;
  logic                in_fire;

  assign out_load  = !out_valid_r || out_tready;
  assign s0_fire   = s0_valid_r && out_load;
  assign in_tready = !s0_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s0_valid_nxt  = in_fire ? 1'b1 : (s0_fire ? 1'b0 : s0_valid_r);
    out_valid_nxt = out_load ? s0_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_frame_r <= in_tuser;
      s0_smp_r   <= sample_t'(in_tdata);
    end
    if (s0_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Mode select: no frame -> zero, switch below threshold -> radio, else joystick
  // ---------------------------------------------------------------------------
  logic radio_mode;
  logic joy_mode;

  assign radio_mode = s0_frame_r && (s0_smp_r.switch_pulse < sw_thresh_r);
  assign joy_mode   = s0_frame_r && !radio_mode;

  // Radio path: forward as is, turn negated
  logic signed [ThrustW-1:0] radio_fwd, radio_turn;

  rcdc_radio_map u_map_fwd (
    .pulse    (s0_smp_r.forward_pulse),
    .negate   (1'b0),
    .deadzone (deadzone_r),
    .thrust   (radio_fwd)
  );

  rcdc_radio_map u_map_turn (
    .pulse    (s0_smp_r.turn_pulse),
    .negate   (1'b1),
    .deadzone (deadzone_r),
    .thrust   (radio_turn)
  );

  // Joystick path; the latch only moves when a joystick item leaves stage 0
  joy_sample_t               joy_smp;
  joy_cfg_t                  joy_cfg;
  logic signed [ThrustW-1:0] joy_fwd, joy_turn;
  logic signed [1:0]         held_fwd, held_turn;

  always_comb begin
    joy_smp.joy_forward = s0_smp_r.joy_forward;
    joy_smp.joy_back    = s0_smp_r.joy_back;
    joy_smp.joy_right   = s0_smp_r.joy_right;
    joy_smp.joy_left    = s0_smp_r.joy_left;
    joy_smp.now_ms      = s0_smp_r.now_ms;
    joy_cfg.joy_speed   = joy_speed_r;
    joy_cfg.hold_ms     = hold_ms_r;
  end

  rcdc_joy_hold u_joy (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (s0_fire && joy_mode),
    .smp         (joy_smp),
    .cfg         (joy_cfg),
    .thrust_fwd  (joy_fwd),
    .thrust_turn (joy_turn),
    .held_fwd_o  (held_fwd),
    .held_turn_o (held_turn)
  );

  always_comb begin
    priority if (radio_mode) begin
      out_data_nxt = {2'b00, radio_turn, radio_fwd};
    end else if (joy_mode) begin
      out_data_nxt = {2'b00, joy_turn, joy_fwd};
    end else begin
      out_data_nxt = '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !s0_valid_r)
    else $error("pipe not empty after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while result stage is empty");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire && !s0_frame_r |=> out_tvalid && out_tdata == '0)
    else $error("nonzero thrust without a radio frame");

  a_held_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    held_fwd != -2'sd2 && held_turn != -2'sd2)
    else $error("latched joystick direction out of range");

endmodule
